// ----- hdl/mosi_snoop_coherence_controller_top_macros.svh -----
`ifndef MOSI_SNOOP_COHERENCE_CONTROLLER_TOP_MACROS_SVH
`define MOSI_SNOOP_COHERENCE_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication, checked on clk, quiet while rst_n is low
`define MSCC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSCC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mscc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mscc_pkg;

  typedef enum logic [2:0] {
    ST_I  = 3'd0,
    ST_S  = 3'd1,
    ST_O  = 3'd2,
    ST_M  = 3'd3,
    ST_IM = 3'd4,
    ST_IS = 3'd5
  } line_state_t;

  typedef enum logic [2:0] {
    MD_LOAD  = 3'd0,
    MD_STORE = 3'd1,
    MD_GETS  = 3'd2,
    MD_GETM  = 3'd3,
    MD_DATA  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    BR_NONE = 2'd0,
    BR_GETS = 2'd1,
    BR_GETM = 2'd2
  } bus_req_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_INVALID = 2'd1,
    ERR_PENDING = 2'd2
  } err_code_t;

  localparam int STATE_W = 3;
  localparam int NODE_W  = 4;
  localparam int ADDR_W  = 32;
  localparam int LIDX_W  = 8;
  localparam int CNT_W   = 32;

  typedef struct packed {
    logic [2:0]        mode;
    logic [LIDX_W-1:0] line_index;
    logic [ADDR_W-1:0] block_address;
    logic [NODE_W-1:0] source_node;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         bus_request;
    logic [ADDR_W-1:0]  request_address;
    logic               data_to_processor;
    logic               data_on_bus;
    logic [NODE_W-1:0]  data_destination;
    logic               shared_asserted;
    logic               miss;
    logic [CNT_W-1:0]   miss_count;
    logic [1:0]         error_code;
    logic [STATE_W-1:0] line_state_after;
  } out_item_t;

  // actions decided for one item by the line state machine
  typedef struct packed {
    bus_req_t    bus_request;
    logic        to_proc;
    logic        on_bus;
    logic        shared;
    logic        miss;
    err_code_t   error_code;
    line_state_t next_state;
  } line_act_t;

endpackage

`default_nettype wire

// ----- hdl/mscc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mscc_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic                   re,
  input  wire logic [AW-1:0]          raddr,
  output logic      [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old contents when the same entry is written in that cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hdl/mscc_line_fsm.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mscc_line_fsm
  import mscc_pkg::*;
(
  input  wire logic [2:0]  mode,
  input  wire line_state_t cur_state,
  output line_act_t        act
);

  logic store;

  assign store = (mode == MD_STORE);

  always_comb begin
    act             = '0;
    act.bus_request = BR_NONE;
    act.error_code  = ERR_NONE;
    act.next_state  = cur_state;
    case (mode)
      MD_LOAD, MD_STORE: begin
        case (cur_state)
          ST_I: begin
            act.bus_request = store ? BR_GETM : BR_GETS;
            act.next_state  = store ? ST_IM : ST_IS;
            act.miss        = 1'b1;
          end
          ST_S, ST_O: begin
            if (store) begin
              act.bus_request = BR_GETM;
              act.next_state  = ST_IM;
              act.miss        = 1'b1;
            end else begin
              act.to_proc = 1'b1;
            end
          end
          ST_M: begin
            act.to_proc = 1'b1;
          end
          ST_IM, ST_IS: begin
            act.error_code = ERR_PENDING;
          end
          default: begin
          end
        endcase
      end
      MD_GETS, MD_GETM, MD_DATA: begin
        case (cur_state)
          ST_S: begin
            if (mode == MD_GETM) begin
              act.next_state = ST_I;
            end
          end
          ST_O, ST_M: begin
            // owner supplies the data on any request
            if (mode != MD_DATA) begin
              act.shared = 1'b1;
              act.on_bus = 1'b1;
              if (mode == MD_GETM) begin
                act.next_state = ST_I;
              end else if (cur_state == ST_M) begin
                act.next_state = ST_O;
              end
            end
          end
          ST_IM: begin
            if (mode == MD_DATA) begin
              act.to_proc    = 1'b1;
              act.next_state = ST_M;
            end
          end
          ST_IS: begin
            if (mode == MD_DATA) begin
              act.to_proc    = 1'b1;
              act.next_state = ST_S;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        act.error_code = ERR_INVALID;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/mosi_snoop_coherence_controller_top.sv -----
// MOSI snooping coherence controller, one state machine per cache line.
// Input channel in_valid / in_stall / in_data: a processor load or store, or a
// snooped GETS, GETM or DATA for one line. Output channel out_valid / out_stall /
// out_data: exactly one result item for each input item, in order.
// The line states live in a single-port-per-direction RAM of LINES entries
// with a registered read. An item reads its line on the accepting edge and is
// held in the decide stage, which decides the action, writes the new state
// back and loads the output register that drives out_valid.
// Back-to-back items to the same line are served by a forwarding register.
// Throughput is one item per cycle unless out_stall holds a result, set by that
// read-modify-write of the RAM. After reset the block sweeps the RAM to state I,
// one entry per cycle, holding in_stall high; the miss total resets to zero.
// When out_stall holds a result, the decide stage holds its item and in_stall
// goes high once that stage is full; no item is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "mosi_snoop_coherence_controller_top_macros.svh"

module mosi_snoop_coherence_controller_top
  import mscc_pkg::*;
#(
  parameter int LINES = 256,
  parameter int NODES = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int NLUT  = 2 ** NODE_W;
  localparam int ILUT  = 2 ** LIDX_W;

  // modulo tables for line index and node
  logic [IDX_W-1:0]  idx_lut [ILUT];
  logic [NODE_W-1:0] src_lut [NLUT];

  for (genvar g = 0; g < ILUT; g++) begin : g_idx_lut
    assign idx_lut[g] = IDX_W'(g % LINES);
  end
  for (genvar g = 0; g < NLUT; g++) begin : g_src_lut
    assign src_lut[g] = NODE_W'(g % NODES);
  end

  logic               clearing_r;
  logic [IDX_W-1:0]   clr_addr_r;
  logic               s1_valid_r;
  logic [IDX_W-1:0]   s1_idx_r;
  logic [2:0]         s1_mode_r;
  logic [ADDR_W-1:0]  s1_addr_r;
  logic [NODE_W-1:0]  s1_src_r;
  logic               fwd_hit_r;
  line_state_t        fwd_state_r;
  logic [CNT_W-1:0]   miss_total_r;
  logic [CNT_W-1:0]   miss_total_nxt;
  logic               out_valid_r;
  out_item_t          out_data_r;
  out_item_t          out_data_nxt;

  logic               in_acc;
  logic               s1_go;
  logic [IDX_W-1:0]   in_idx;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [STATE_W-1:0] ram_wdata;
  logic [STATE_W-1:0] ram_rdata;
  line_state_t        cur_state;
  line_act_t          act;

  assign in_idx   = idx_lut[in_data.line_index];
  assign s1_go    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clearing_r || (s1_valid_r && !s1_go);
  assign in_acc   = in_valid && !in_stall;

  assign ram_we    = clearing_r || s1_go;
  assign ram_waddr = clearing_r ? clr_addr_r : s1_idx_r;
  assign ram_wdata = clearing_r ? STATE_W'(ST_I) : STATE_W'(act.next_state);

  mscc_ram #(
    .WIDTH (STATE_W),
    .DEPTH (LINES)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  // the RAM read misses the write made on the same edge, take it from here
  assign cur_state = fwd_hit_r ? fwd_state_r : line_state_t'(ram_rdata);

  mscc_line_fsm u_line_fsm (
    .mode      (s1_mode_r),
    .cur_state (cur_state),
    .act       (act)
  );

  assign miss_total_nxt = miss_total_r + CNT_W'(act.miss);

  always_comb begin
    out_data_nxt                   = '0;
    out_data_nxt.bus_request       = act.bus_request;
    out_data_nxt.request_address   =
      (act.bus_request != BR_NONE || act.to_proc || act.on_bus) ? s1_addr_r : '0;
    out_data_nxt.data_to_processor = act.to_proc;
    out_data_nxt.data_on_bus       = act.on_bus;
    out_data_nxt.data_destination  = act.on_bus ? s1_src_r : '0;
    out_data_nxt.shared_asserted   = act.shared;
    out_data_nxt.miss              = act.miss;
    out_data_nxt.miss_count        = miss_total_nxt;
    out_data_nxt.error_code        = act.error_code;
    out_data_nxt.line_state_after  = act.next_state;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r   <= 1'b1;
      clr_addr_r   <= '0;
      s1_valid_r   <= 1'b0;
      fwd_hit_r    <= 1'b0;
      miss_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (clearing_r) begin
        if (clr_addr_r == IDX_W'(LINES - 1)) begin
          clearing_r <= 1'b0;
        end else begin
          clr_addr_r <= clr_addr_r + IDX_W'(1);
        end
      end
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        fwd_hit_r  <= s1_go && (s1_idx_r == in_idx);
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        miss_total_r <= miss_total_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_idx_r    <= in_idx;
      s1_mode_r   <= in_data.mode;
      s1_addr_r   <= in_data.block_address;
      s1_src_r    <= src_lut[in_data.source_node];
      fwd_state_r <= act.next_state;
    end
    if (s1_go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MSCC_ASSERT_NXT(a_miss_step, s1_go && act.miss, miss_total_r == $past(miss_total_r) + 32'd1, "miss total did not advance by one")
  `MSCC_ASSERT_IMP(a_pending_holds, s1_valid_r && act.error_code == ERR_PENDING, act.next_state == cur_state, "pending line changed state")
  `MSCC_ASSERT_IMP(a_supply_shared, out_valid_r, out_data_r.data_on_bus == out_data_r.shared_asserted, "bus data without shared line")
  `MSCC_ASSERT_IMP(a_clear_empty, $fell(clearing_r), !s1_valid_r && !out_valid_r, "item in flight during clearing")

endmodule

`default_nettype wire

// ----- dv/mosi_snoop_coherence_controller_top_test.sv -----
`timescale 1ns / 1ps

module mosi_snoop_coherence_controller_top_test;
  import mscc_pkg::*;

  localparam int LINES = 256;
  localparam int NODES = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  mosi_snoop_coherence_controller_top #(
    .LINES(LINES),
    .NODES(NODES)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the line states and the miss total
  line_state_t   shadow_lines [LINES];
  logic [31:0]   shadow_misses = '0;
  out_item_t     pending_results [$];
  out_item_t     want_result;

  int unsigned fail_count = 0;
  int unsigned results_checked = 0;
  int unsigned cycle_count = 0;
  int unsigned n_loads = 0;
  int unsigned n_stores = 0;
  int unsigned n_snoops = 0;
  int unsigned n_bad_modes = 0;
  int unsigned burst_left = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_run = 0;

  initial begin
    for (int i = 0; i < LINES; i++) shadow_lines[i] = ST_I;
  end

  function automatic out_item_t predict_coherence(in_item_t it);
    out_item_t   r;
    line_state_t st;
    int unsigned idx;
    idx = it.line_index % LINES;
    st = shadow_lines[idx];
    r = '0;
    case (it.mode)
      MD_LOAD, MD_STORE: begin
        case (st)
          ST_I: begin
            r.miss = 1'b1;
            if (it.mode == MD_STORE) begin
              r.bus_request = BR_GETM;
              st = ST_IM;
            end else begin
              r.bus_request = BR_GETS;
              st = ST_IS;
            end
          end
          ST_S, ST_O: begin
            if (it.mode == MD_STORE) begin
              r.bus_request = BR_GETM;
              r.miss = 1'b1;
              st = ST_IM;
            end else begin
              r.data_to_processor = 1'b1;
            end
          end
          ST_M: r.data_to_processor = 1'b1;
          default: r.error_code = ERR_PENDING;
        endcase
      end
      MD_GETS, MD_GETM, MD_DATA: begin
        case (st)
          ST_S: if (it.mode == MD_GETM) st = ST_I;
          ST_O, ST_M: begin
            if (it.mode != MD_DATA) begin
              r.shared_asserted = 1'b1;
              r.data_on_bus = 1'b1;
              if (it.mode == MD_GETM) st = ST_I;
              else if (st == ST_M) st = ST_O;
            end
          end
          ST_IM: begin
            if (it.mode == MD_DATA) begin
              r.data_to_processor = 1'b1;
              st = ST_M;
            end
          end
          ST_IS: begin
            if (it.mode == MD_DATA) begin
              r.data_to_processor = 1'b1;
              st = ST_S;
            end
          end
          default: ;
        endcase
      end
      default: r.error_code = ERR_INVALID;
    endcase
    if (r.miss) shadow_misses = shadow_misses + 32'd1;
    if (r.bus_request != BR_NONE || r.data_to_processor || r.data_on_bus)
      r.request_address = it.block_address;
    if (r.data_on_bus) r.data_destination = 4'(it.source_node % NODES);
    r.miss_count = shadow_misses;
    r.line_state_after = st;
    shadow_lines[idx] = st;
    return r;
  endfunction

  function automatic in_item_t mk_item(logic [2:0] mode, logic [7:0] line,
                                       logic [31:0] addr, logic [3:0] node);
    in_item_t it;
    it.mode = mode;
    it.line_index = line;
    it.block_address = addr;
    it.source_node = node;
    return it;
  endfunction

  function automatic in_item_t rand_item(bit hot_lines);
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 22) it.mode = MD_LOAD;
    else if (pick < 40) it.mode = MD_STORE;
    else if (pick < 58) it.mode = MD_GETS;
    else if (pick < 70) it.mode = MD_GETM;
    else if (pick < 94) it.mode = MD_DATA;
    else it.mode = 3'($urandom_range(MD_DATA + 1, (1 << $bits(it.mode)) - 1));
    if (hot_lines) begin
      // a few lines at both ends of the store, so states pile up
      pick = $urandom_range(0, 7);
      it.line_index = (pick < 4) ? 8'(pick) : 8'(LINES - 8 + pick);
    end else begin
      it.line_index = 8'($urandom_range(0, LINES - 1));
    end
    pick = $urandom_range(0, 15);
    if (pick == 0) it.block_address = '0;
    else if (pick == 1) it.block_address = '1;
    else it.block_address = $urandom;
    it.source_node = 4'($urandom_range(0, NODES - 1));
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_coherence(it));
    case (it.mode)
      MD_LOAD: n_loads++;
      MD_STORE: n_stores++;
      MD_GETS, MD_GETM, MD_DATA: n_snoops++;
      default: n_bad_modes++;
    endcase
    @(negedge clk);
  endtask

  task automatic idle_cycles(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // bursts of random length, sometimes long ones with no gap at all
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 40);
      idle_cycles(($urandom_range(0, 15) == 0) ? 20 : $urandom_range(1, 7));
    end else begin
      burst_left--;
    end
  endtask

  task automatic test_directed();
    send_item(mk_item(MD_LOAD, 8'd0, 32'h0, 4'd0));
    send_item(mk_item(MD_LOAD, 8'd0, $urandom, 4'd0));
    send_item(mk_item(MD_STORE, 8'd0, $urandom, 4'd3));
    send_item(mk_item(MD_DATA, 8'd0, 32'h0, 4'd0));
    send_item(mk_item(MD_LOAD, 8'd0, $urandom, 4'd1));
    send_item(mk_item(MD_GETS, 8'd0, $urandom, 4'd2));
    send_item(mk_item(MD_STORE, 8'd0, 32'hFFFF_FFFF, 4'd0));
    send_item(mk_item(MD_GETS, 8'd0, $urandom, 4'd9));
    send_item(mk_item(MD_DATA, 8'd0, $urandom, 4'd0));
    send_item(mk_item(MD_STORE, 8'd0, $urandom, 4'd0));
    send_item(mk_item(MD_GETS, 8'd0, 32'hFFFF_FFFF, 4'd15));
    send_item(mk_item(MD_GETS, 8'd0, $urandom, 4'd7));
    send_item(mk_item(MD_LOAD, 8'd0, $urandom, 4'd0));
    send_item(mk_item(MD_DATA, 8'd0, $urandom, 4'd0));
    send_item(mk_item(MD_STORE, 8'd0, $urandom, 4'd0));
    send_item(mk_item(MD_DATA, 8'd0, $urandom, 4'd0));
    send_item(mk_item(MD_GETM, 8'd0, 32'h0, 4'd15));
    send_item(mk_item(MD_GETS, 8'd0, $urandom, 4'd4));
    send_item(mk_item(MD_LOAD, 8'd255, 32'hFFFF_FFFF, 4'd15));
    send_item(mk_item(MD_DATA, 8'd255, $urandom, 4'd0));
    send_item(mk_item(MD_GETM, 8'd255, $urandom, 4'd5));
    send_item(mk_item(MD_STORE, 8'd255, $urandom, 4'd0));
    send_item(mk_item(MD_DATA, 8'd255, $urandom, 4'd0));
    send_item(mk_item(MD_GETS, 8'd255, $urandom, 4'd10));
    send_item(mk_item(MD_GETM, 8'd255, 32'hFFFF_FFFF, 4'd0));
    // modes above snoop data are illegal
    for (int m = MD_DATA + 1; m < (1 << $bits(in_data.mode)); m++)
      send_item(mk_item(3'(m), 8'd128, 32'hFFFF_FFFF, 4'd15));
  endtask

  // processor request, sometimes a random item, its data, then a snoop or a processor request on the same line
  task automatic test_transactions(input int unsigned rounds);
    logic [7:0] line;
    logic [2:0] m;
    repeat (rounds) begin
      line = 8'($urandom_range(0, LINES - 1));
      m = ($urandom_range(0, 1) == 0) ? MD_LOAD : MD_STORE;
      send_item(mk_item(m, line, $urandom, 4'($urandom_range(0, NODES - 1))));
      pace();
      if ($urandom_range(0, 3) == 0) begin
        send_item(rand_item(1'b0));
        pace();
      end
      send_item(mk_item(MD_DATA, line, $urandom, 4'($urandom_range(0, NODES - 1))));
      pace();
      case ($urandom_range(0, 3))
        0: m = MD_GETS;
        1: m = MD_GETM;
        2: m = MD_LOAD;
        default: m = MD_STORE;
      endcase
      send_item(mk_item(m, line, $urandom, 4'($urandom_range(0, NODES - 1))));
      pace();
    end
  endtask

  task automatic test_random_items(input int unsigned count, input bit hot_lines);
    repeat (count) begin
      send_item(rand_item(hot_lines));
      pace();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result item with no expectation waiting");
        fail_count++;
      end else begin
        want_result = pending_results.pop_front();
        check_field("bus_request", 32'(want_result.bus_request), 32'(out_data.bus_request));
        check_field("request_address", want_result.request_address,
                    out_data.request_address);
        check_field("data_to_processor", 32'(want_result.data_to_processor),
                    32'(out_data.data_to_processor));
        check_field("data_on_bus", 32'(want_result.data_on_bus), 32'(out_data.data_on_bus));
        check_field("data_destination", 32'(want_result.data_destination),
                    32'(out_data.data_destination));
        check_field("shared_asserted", 32'(want_result.shared_asserted),
                    32'(out_data.shared_asserted));
        check_field("miss", 32'(want_result.miss), 32'(out_data.miss));
        check_field("miss_count", want_result.miss_count, out_data.miss_count);
        check_field("error_code", 32'(want_result.error_code), 32'(out_data.error_code));
        check_field("line_state_after", 32'(want_result.line_state_after),
                    32'(out_data.line_state_after));
        results_checked++;
      end
    end
  end

  // receiver backpressure: runs of random length at a varying stall rate
  always @(negedge clk) begin
    if (stall_run == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 15;
        2: stall_pct <= 40;
        default: stall_pct <= 75;
      endcase
      stall_run <= $urandom_range(20, 300);
      out_stall <= 1'b0;
    end else begin
      stall_run <= stall_run - 1;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** mosi_snoop_coherence_controller_top: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    wait_results_drained();
    test_transactions(150);
    wait_results_drained();
    test_random_items(600, 1'b1);
    wait_results_drained();
    test_random_items(400, 1'b0);
    wait_results_drained();
    repeat (8) @(posedge clk);
    $display("checked %0d results: %0d loads, %0d stores, %0d snoops, %0d illegal modes",
             results_checked, n_loads, n_stores, n_snoops, n_bad_modes);
    $display("misses counted %0d, receiver and sender idling at random throughout",
             shadow_misses);
    if (fail_count == 0) begin
      $display("** mosi_snoop_coherence_controller_top: PASSED **");
    end else begin
      $display("** mosi_snoop_coherence_controller_top: FAILED **");
    end
    $finish;
  end

endmodule
